>>> hw/rtl/euclidean_distance_top_macros.svh
// ----------------------------------------------------------------------------
// Euclidean distance assertion macros
// Shorthand for the concurrent checks of the euclidean distance block.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_TOP_MACROS_SVH
`define EUCLIDEAN_DISTANCE_TOP_MACROS_SVH

// Check sampled on the rising clock edge and ignored while reset is high.
`define ED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check sampled on the rising clock edge that also holds during reset.
`define ED_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/euc_dist_pkg.sv
// ----------------------------------------------------------------------------
// Euclidean distance package
// Fixed widths and limits shared by the distance block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package euc_dist_pkg;

  localparam int SUM_BITS  = 45;
  localparam int DIST_BITS = 30;
  // Number of two-bit digit groups that cover the sum of squares.
  localparam int SUM_PAIRS = (SUM_BITS + 1) / 2;
  localparam int M_TDATA_W = ((DIST_BITS + 7) / 8) * 8;

  localparam logic [SUM_BITS-1:0]  SUM_MAX  = '1;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

endpackage

`default_nettype wire

>>> hw/rtl/euclidean_distance_top.sv
// ----------------------------------------------------------------------------
// Euclidean distance top level
// Streaming L2 norm of the difference of two vectors, fixed point result.
// ----------------------------------------------------------------------------
// Each slave beat carries one document element and the matching query element
// in s_tdata, a pair flag in s_tuser and the end of the vector in s_tlast. The
// squared difference is added to a saturating 45-bit sum. The beat with s_tlast
// high produces one master beat: the floor of the square root of the sum with
// FRACTION_BITS fraction bits, clamped to DIST_MAX, in m_tdata, and the sum
// saturation flag in m_tuser. A beat with neither pair nor tlast has no effect.
// Timing: after a pair beat s_tready stays low through one multiply and one
// saturating add, so no new beat is taken until both are done. A last beat
// adds the square root, computed by one shared compare/subtract unit that
// retires one result bit per cycle, and then the emit state loads the output
// register, waiting while an earlier result is still unread. m_tvalid rises
// and s_tready returns in the same cycle.
// The output register decouples the sides: new input beats are taken while a
// result waits; only a second result waits for m_tready before it is loaded.
// Reset clears the sum, the saturation flag, the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_distance_top
  import euc_dist_pkg::*;
#(
  parameter int ELEMENT_BITS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  wire                                         clk,
  input  wire                                         rst,
  input  wire                                         s_tvalid,
  output logic                                        s_tready,
  // s_tdata: doc_element, query_element (low bit up), zero padded
  input  wire  [((2*ELEMENT_BITS+7)/8)*8-1:0]         s_tdata,
  // s_tuser: has_pair
  input  wire                                         s_tuser,
  input  wire                                         s_tlast,
  output logic                                        m_tvalid,
  input  wire                                         m_tready,
  // m_tdata: distance, zero padded
  output logic [M_TDATA_W-1:0]                        m_tdata,
  // m_tuser: saturated
  output logic                                        m_tuser
);

  localparam int MAG_W   = ELEMENT_BITS + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ADD_W   = ((SQ_W > SUM_BITS) ? SQ_W : SUM_BITS) + 1;
  localparam int ROOT_W  = SUM_PAIRS + FRACTION_BITS;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CNT_W   = $clog2(ROOT_W + 1);
  localparam int CMP_W   = (ROOT_W > DIST_BITS) ? ROOT_W : DIST_BITS;
  localparam int SHIFT_W = 2 * SUM_PAIRS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_EMIT
  } state_t;

  state_t                state;
  logic [MAG_W-1:0]      mag;
  logic [SQ_W-1:0]       square;
  logic                  last_item;
  logic [SUM_BITS-1:0]   sum;
  logic                  overflow;
  logic [SHIFT_W-1:0]    shifter;
  logic [REM_W-1:0]      rem;
  logic [ROOT_W-1:0]     root;
  logic [CNT_W-1:0]      count;

  logic [ELEMENT_BITS-1:0] doc_element;
  logic [ELEMENT_BITS-1:0] query_element;
  logic [MAG_W-1:0]        diff;
  logic [MAG_W-1:0]        mag_next;
  logic [ADD_W-1:0]        sum_ext;
  logic                    sum_sat;
  logic [SUM_BITS-1:0]     sum_next;
  logic [1:0]              pair;
  logic [REM_W-1:0]        rem_shift;
  logic [REM_W-1:0]        trial;
  logic                    take_bit;
  logic [REM_W-1:0]        rem_next;
  logic [ROOT_W-1:0]       root_next;
  logic [CMP_W-1:0]        root_ext;
  logic [DIST_BITS-1:0]    distance;

  assign doc_element   = s_tdata[ELEMENT_BITS-1:0];
  assign query_element = s_tdata[2*ELEMENT_BITS-1:ELEMENT_BITS];

  assign s_tready = (state == ST_IDLE);

  // Sign-extended difference and its magnitude; 2^ELEMENT_BITS - 1 at most.
  assign diff     = {doc_element[ELEMENT_BITS-1], doc_element}
                  - {query_element[ELEMENT_BITS-1], query_element};
  assign mag_next = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

  assign sum_ext  = ADD_W'(sum) + ADD_W'(square);
  assign sum_sat  = (sum_ext > ADD_W'(SUM_MAX));
  assign sum_next = sum_sat ? SUM_MAX : sum_ext[SUM_BITS-1:0];

  // One digit of the restoring square root. Once the sum's digits are used up,
  // zeros shift in and the fraction bits follow with the same step.
  assign pair      = shifter[SHIFT_W-1 -: 2];
  assign rem_shift = {rem[REM_W-3:0], pair};
  assign trial     = {root, 2'b01};
  assign take_bit  = (rem_shift >= trial);
  assign rem_next  = take_bit ? (rem_shift - trial) : rem_shift;
  assign root_next = {root[ROOT_W-2:0], take_bit};

  assign root_ext  = CMP_W'(root);
  assign distance  = (root_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sum      <= '0;
      overflow <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // The emit state drives m_tvalid itself.
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mag       <= mag_next;
            last_item <= s_tlast;
            if (s_tuser) begin
              state <= ST_SQUARE;
            end else if (s_tlast) begin
              shifter <= SHIFT_W'(sum);
              rem     <= '0;
              root    <= '0;
              count   <= CNT_W'(ROOT_W);
              state   <= ST_ROOT;
            end
          end
        end
        ST_SQUARE: begin
          square <= SQ_W'(mag) * SQ_W'(mag);
          state  <= ST_ACCUM;
        end
        ST_ACCUM: begin
          sum <= sum_next;
          if (sum_sat) begin
            overflow <= 1'b1;
          end
          if (last_item) begin
            shifter <= SHIFT_W'(sum_next);
            rem     <= '0;
            root    <= '0;
            count   <= CNT_W'(ROOT_W);
            state   <= ST_ROOT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_ROOT: begin
          shifter <= {shifter[SHIFT_W-3:0], 2'b00};
          rem     <= rem_next;
          root    <= root_next;
          count   <= count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Wait here only while an earlier result still sits unread.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_TDATA_W'(distance);
            m_tuser  <= overflow;
            sum      <= '0;
            overflow <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/euc_dist_checker.sv
// ----------------------------------------------------------------------------
// Euclidean distance checker
// Port-level checks of the distance block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "euclidean_distance_top_macros.svh"

module euc_dist_checker
  import euc_dist_pkg::*;
(
  input wire                 clk,
  input wire                 rst,
  input wire                 s_tvalid,
  input wire                 s_tready,
  input wire                 s_tuser,
  input wire                 s_tlast,
  input wire                 m_tvalid,
  input wire                 m_tready,
  input wire [M_TDATA_W-1:0] m_tdata,
  input wire                 m_tuser
);

  // A stalled result beat keeps its value until it is taken.
  `ED_ASSERT(a_hold_result, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // A beat that carries a pair or ends a vector keeps the block busy afterward.
  `ED_ASSERT(a_busy_after_work, s_tvalid && s_tready && (s_tuser || s_tlast) |=> !s_tready, "input taken while an item is still in work")

  // No result is shown right after reset.
  `ED_ASSERT_RST(a_reset_clears_out, rst |=> !m_tvalid, "result beat valid after reset")

endmodule

bind euclidean_distance_top euc_dist_checker u_euc_dist_checker (.*);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Euclidean distance testbench
// Streams element pairs into the distance block and checks every result beat
// against a local prediction: saturating sum of squared differences, fixed
// point square root with a clamp, and the saturation flag. Covers extreme
// elements, empty vectors, ignored beats, runs of the largest differences,
// output stalls and random vectors, with random idle bursts on both sides.
// Sum saturation needs more than 8192 beats of the largest difference and lies
// beyond the length of this run.
// ----------------------------------------------------------------------------

module tb;
  import euc_dist_pkg::*;

  localparam int EL_W        = 16;
  localparam int FRAC_BITS   = 8;
  localparam int S_TDATA_W   = ((2*EL_W+7)/8)*8;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 64;
  localparam logic [63:0] SUM_LIMIT = {{(64-SUM_BITS){1'b0}}, SUM_MAX};

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 saturated;
  } dist_result_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  dist_result_t pending_dists[$];
  logic [63:0]  acc_sum;
  bit           acc_saturated;
  int           errors;
  bit           idle_on;
  int           hold_reqs;
  int           hold_done;

  euclidean_distance_top #(
    .ELEMENT_BITS (EL_W),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Floor of sqrt(s * 4^FRAC_BITS), found bit by bit from the top, then clamped.
  function automatic logic [DIST_BITS-1:0] fixed_root(input logic [63:0] s);
    logic [63:0] target;
    logic [63:0] root;
    logic [63:0] cand;
    target = s << (2*FRAC_BITS);
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= target) begin
        root = cand;
      end
    end
    if (root > {{(64-DIST_BITS){1'b0}}, DIST_MAX}) begin
      return DIST_MAX;
    end
    return root[DIST_BITS-1:0];
  endfunction

  task automatic accumulate_beat(input logic [EL_W-1:0] doc, input logic [EL_W-1:0] query,
                                 input bit pair, input bit fin);
    longint          diff;
    longint unsigned mag;
    logic [63:0]     sq;
    dist_result_t    res;
    if (pair) begin
      diff = longint'($signed(doc)) - longint'($signed(query));
      mag = (diff < 0) ? longint'(-diff) : longint'(diff);
      sq = mag * mag;
      if (sq > SUM_LIMIT - acc_sum) begin
        acc_sum = SUM_LIMIT;
        acc_saturated = 1'b1;
      end else begin
        acc_sum = acc_sum + sq;
      end
    end
    if (fin) begin
      res.distance = fixed_root(acc_sum);
      res.saturated = acc_saturated;
      pending_dists.push_back(res);
      acc_sum = '0;
      acc_saturated = 1'b0;
    end
  endtask

  function automatic logic [EL_W-1:0] rand_elem();
    int pick;
    int v;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      return 16'sh7fff;
    end else if (pick == 1) begin
      return 16'sh8000;
    end else if (pick <= 3) begin
      v = $urandom_range(0, 16);
      return 16'(v - 8);
    end
    return 16'($urandom);
  endfunction

  // One input beat; the expectation is recorded at the edge that accepts it.
  task automatic send_beat(input logic [EL_W-1:0] doc, input logic [EL_W-1:0] query,
                           input bit pair, input bit fin);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {query, doc};
    s_tuser  <= pair;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    accumulate_beat(doc, query, pair, fin);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_dists.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // A run of pairs with the largest possible difference, in either direction.
  task automatic send_max_run(input int count, input bit close_with_pair);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 1)) begin
        send_beat(16'sh7fff, 16'sh8000, 1'b1, close_with_pair && (k == count - 1));
      end else begin
        send_beat(16'sh8000, 16'sh7fff, 1'b1, close_with_pair && (k == count - 1));
      end
    end
    if (!close_with_pair) begin
      send_beat(rand_elem(), rand_elem(), 1'b0, 1'b1);
    end
  endtask

  task automatic test_directed();
    send_beat(16'h0000, 16'h0000, 1'b0, 1'b1);         // empty vector right after reset
    send_beat(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
    send_beat(16'sh8000, 16'sh7fff, 1'b1, 1'b1);
    send_beat(16'hffff, 16'hffff, 1'b1, 1'b1);          // equal elements
    send_beat(16'h0001, 16'h0000, 1'b1, 1'b0);
    send_beat(16'ha5c3, 16'h3c5a, 1'b0, 1'b0);          // ignored beat mid vector
    send_beat(16'h0000, 16'h0001, 1'b1, 1'b0);
    send_beat(16'h5a3c, 16'hc3a5, 1'b0, 1'b1);          // close without a pair
    send_beat(16'hffff, 16'hffff, 1'b0, 1'b1);          // empty vector with data set
    send_beat(16'h0003, 16'hfffd, 1'b1, 1'b0);
    send_beat(16'h0004, 16'h0000, 1'b1, 1'b1);
    send_beat(16'h7fff, 16'h7fff, 1'b1, 1'b0);
    send_beat(16'h8000, 16'h8000, 1'b1, 1'b0);
    send_beat(16'h0000, 16'h8000, 1'b1, 1'b0);
    send_beat(16'h7fff, 16'h0000, 1'b1, 1'b1);
    send_beat(16'hfff0, 16'h000f, 1'b1, 1'b1);
  endtask

  task automatic test_max_runs();
    send_max_run(40, 1'b0);     // large sum closed by a bare tlast beat
    send_max_run(25, 1'b1);     // large sum closed by its last pair
    send_max_run(12, 1'b0);
    send_beat(16'h0002, 16'h0000, 1'b1, 1'b1);
  endtask

  task automatic test_output_stall();
    hold_reqs++;
    for (int v = 0; v < 8; v++) begin
      for (int k = 0; k < 3; k++) begin
        send_beat(rand_elem(), rand_elem(), 1'b1, k == 2);
      end
    end
  endtask

  task automatic test_random_vectors(input int item_goal);
    int sent;
    int len;
    bit close_pair;
    sent = 0;
    while (sent < item_goal) begin
      if (sent > item_goal - 200) begin
        idle_on = 1'b0;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      close_pair = $urandom_range(0, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_beat(rand_elem(), rand_elem(), 1'b0, 1'b0);
        end
        send_beat(rand_elem(), rand_elem(), 1'b1, close_pair && (k == len - 1));
        sent++;
      end
      if (len == 0 || !close_pair) begin
        send_beat(rand_elem(), rand_elem(), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  // Receiver: random idle bursts, plus a long hold-off whenever one is requested.
  initial begin
    int gap_left;
    int hold_left;
    gap_left = 0;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 10) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    dist_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_dists.size() == 0) begin
        $error("unexpected result beat: distance %0d saturated %0d",
               m_tdata[DIST_BITS-1:0], m_tuser);
        errors++;
      end else begin
        want = pending_dists.pop_front();
        if (m_tdata[DIST_BITS-1:0] !== want.distance) begin
          $error("distance: expected %0d, actual %0d", want.distance, m_tdata[DIST_BITS-1:0]);
          errors++;
        end
        if (m_tdata[M_TDATA_W-1:DIST_BITS] !== '0) begin
          $error("m_tdata padding: expected 0, actual %0d", m_tdata[M_TDATA_W-1:DIST_BITS]);
          errors++;
        end
        if (m_tuser !== want.saturated) begin
          $error("saturated: expected %0d, actual %0d", want.saturated, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    acc_sum = '0;
    acc_saturated = 1'b0;
    errors = 0;
    idle_on = 1'b1;
    hold_reqs = 0;
    hold_done = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_max_runs();
    test_output_stall();
    wait_for_results();
    test_random_vectors(1050);

    wait_for_results();
    if (errors == 0 && pending_dists.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
